/* rtl/lru_page_replacement_core_assert.svh */
// Assertion macros shared by the page replacement core.
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define LRUPR_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRUPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lrupr_pkg.sv */
`default_nettype none

package lrupr_pkg;

  localparam int PAGES_DEF      = 64;
  localparam int STAMP_BITS_DEF = 32;

  localparam int PAGE_W    = 6;
  localparam int ACT_W     = 2;
  localparam int FREE_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;

  localparam logic [ACT_W-1:0] ACT_TOUCH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FAULT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PREPAGING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FREE = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic decode;
    logic scan_clr;
    logic scan_en;
    logic evict1;
    logic evict2;
    logic prefetch;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_ok;
    logic is_fault;
    logic prepaging;
    logic scan_done;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/lrupr_ram.sv */
`default_nettype none

module lrupr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/lrupr_ctrl.sv */
`default_nettype none

module lrupr_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire lrupr_pkg::dp_sts_t sts_i,
  output lrupr_pkg::dp_cmd_t      cmd_o,
  output logic                    busy_o,
  output logic                    done_o
);

  import lrupr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN1  = 3'd2;
  localparam logic [2:0] S_EVICT1 = 3'd3;
  localparam logic [2:0] S_SCAN2  = 3'd4;
  localparam logic [2:0] S_EVICT2 = 3'd5;
  localparam logic [2:0] S_PREF   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.scan_clr = 1'b1;
        cmd_o.decode   = 1'b1;
        if (sts_i.item_ok && sts_i.is_fault) begin
          state_d = S_SCAN1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN1: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EVICT1;
        end
      end
      S_EVICT1: begin
        cmd_o.evict1   = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = sts_i.prepaging ? S_SCAN2 : S_DONE;
      end
      S_SCAN2: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EVICT2;
        end
      end
      S_EVICT2: begin
        cmd_o.evict2 = 1'b1;
        state_d      = S_PREF;
      end
      S_PREF: begin
        cmd_o.prefetch = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        done_o       = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/lrupr_dp.sv */
`default_nettype none

module lrupr_dp #(
  parameter int STAMP_BITS = lrupr_pkg::STAMP_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire lrupr_pkg::dp_cmd_t             cmd_i,
  output lrupr_pkg::dp_sts_t                  sts_o,
  input  wire  [lrupr_pkg::ACT_W-1:0]         action_i,
  input  wire  [lrupr_pkg::PAGE_W-1:0]        page_index_i,
  input  wire                                 cfg_we_i,
  input  wire  [lrupr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [lrupr_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                                evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]        evicted_index_o,
  output logic                                second_evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]        second_evicted_index_o,
  output logic                                prefetched_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]        prefetched_index_o
);

  import lrupr_pkg::*;

  localparam int PAGES = PAGES_DEF;
  localparam int IDX_W = $clog2(PAGES);
  localparam int CNT_W = $clog2(PAGES + 1);

  logic [PAGES-1:0]      valid_q, valid_d;
  logic [STAMP_BITS-1:0] clock_q;
  logic [FREE_W-1:0]     free_q, free_d;
  logic                  prepaging_q;

  logic [ACT_W-1:0]      act_q;
  logic [IDX_W-1:0]      pg_q;
  logic                  ok_q;

  // Scan pipeline: read issue, then compare in the next cycle.
  logic [CNT_W-1:0]      addr_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  issue;
  logic [STAMP_BITS-1:0] rdata;

  logic                  found_q;
  logic [IDX_W-1:0]      best_q;
  logic [STAMP_BITS-1:0] best_stamp_q;
  logic                  pf_found_q;
  logic [IDX_W-1:0]      pf_idx_q;

  logic                  ev_v_q, sev_v_q, pf_v_q;
  logic [IDX_W-1:0]      ev_i_q, sev_i_q, pf_i_q;

  logic                  in_ok;
  logic                  sec_ev;
  logic                  sec_first;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;

  assign in_ok = (action_i != ACT_NONE) &&
                 ({{(32-PAGE_W){1'b0}}, page_index_i} < 32'(PAGES));

  assign issue = cmd_i.scan_en && (addr_q != CNT_W'(PAGES));

  // A second victim is taken only when no frame is free at that point.
  assign sec_ev    = (free_q == '0) && found_q;
  assign sec_first = sec_ev && (best_q > pg_q) && (!pf_found_q || (best_q < pf_idx_q));

  assign sts_o.item_ok   = ok_q;
  assign sts_o.is_fault  = (act_q == ACT_FAULT);
  assign sts_o.prepaging = prepaging_q;
  assign sts_o.scan_done = (addr_q == CNT_W'(PAGES)) && !rd_vld_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pg_q;
    if (cmd_i.decode && ok_q && (act_q != ACT_FAULT)) begin
      ram_we = 1'b1;
    end
    if (cmd_i.evict1) begin
      ram_we = 1'b1;
    end
    if (cmd_i.evict2 && sec_ev) begin
      ram_we    = 1'b1;
      ram_waddr = best_q;
    end
    if (cmd_i.prefetch && pf_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = pf_i_q;
    end
  end

  lrupr_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (PAGES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (clock_q),
    .re_i    (issue),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    valid_d = valid_q;
    free_d  = free_q;
    if (cfg_we_i && (cfg_index_i == CFG_INIT_FREE)) begin
      free_d = cfg_data_i[FREE_W-1:0];
    end
    if (cmd_i.decode && ok_q && (act_q == ACT_FILL) && !valid_q[pg_q]) begin
      valid_d[pg_q] = 1'b1;
      if (free_q != '0) begin
        free_d = free_q - FREE_W'(1);
      end
    end
    if (cmd_i.evict1) begin
      // Clear the victim first: a faulting page that is its own victim ends valid.
      if (found_q) begin
        valid_d[best_q] = 1'b0;
      end
      valid_d[pg_q] = 1'b1;
    end
    if (cmd_i.evict2) begin
      if (sec_ev) begin
        valid_d[best_q] = 1'b0;
      end
      if (free_q == '0) begin
        free_d = FREE_W'(1);
      end
    end
    if (cmd_i.prefetch && pf_v_q) begin
      valid_d[pf_i_q] = 1'b1;
      if (free_q != '0) begin
        free_d = free_q - FREE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      clock_q     <= '0;
      free_q      <= '0;
      prepaging_q <= 1'b0;
      ok_q        <= 1'b0;
      act_q       <= ACT_NONE;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      pf_found_q  <= 1'b0;
      ev_v_q      <= 1'b0;
      sev_v_q     <= 1'b0;
      pf_v_q      <= 1'b0;
    end else begin
      valid_q <= valid_d;
      free_q  <= free_d;
      if (cfg_we_i && (cfg_index_i == CFG_PREPAGING)) begin
        prepaging_q <= cfg_data_i[0];
      end
      if (cmd_i.latch) begin
        act_q   <= action_i;
        ok_q    <= in_ok;
        ev_v_q  <= 1'b0;
        sev_v_q <= 1'b0;
        pf_v_q  <= 1'b0;
      end
      if (cmd_i.finish && ok_q && (clock_q != '1)) begin
        clock_q <= clock_q + STAMP_BITS'(1);
      end
      rd_vld_q <= issue;
      if (cmd_i.scan_clr) begin
        addr_q     <= '0;
        found_q    <= 1'b0;
        pf_found_q <= 1'b0;
      end else begin
        if (issue) begin
          addr_q <= addr_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          if (valid_q[rd_idx_q] && (!found_q || (rdata < best_stamp_q))) begin
            found_q <= 1'b1;
          end
          if (!valid_q[rd_idx_q] && (rd_idx_q > pg_q) && !pf_found_q) begin
            pf_found_q <= 1'b1;
          end
        end
      end
      if (cmd_i.evict1) begin
        ev_v_q <= found_q;
      end
      if (cmd_i.evict2) begin
        sev_v_q <= sec_ev;
        pf_v_q  <= sec_first || pf_found_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      pg_q    <= IDX_W'(page_index_i);
      ev_i_q  <= '0;
      sev_i_q <= '0;
      pf_i_q  <= '0;
    end
    rd_idx_q <= addr_q[IDX_W-1:0];
    if (!cmd_i.scan_clr && rd_vld_q) begin
      if (valid_q[rd_idx_q] && (!found_q || (rdata < best_stamp_q))) begin
        best_q       <= rd_idx_q;
        best_stamp_q <= rdata;
      end
      if (!valid_q[rd_idx_q] && (rd_idx_q > pg_q) && !pf_found_q) begin
        pf_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.evict1) begin
      ev_i_q <= found_q ? best_q : '0;
    end
    if (cmd_i.evict2) begin
      sev_i_q <= sec_ev ? best_q : '0;
      if (sec_first) begin
        pf_i_q <= best_q;
      end else if (pf_found_q) begin
        pf_i_q <= pf_idx_q;
      end else begin
        pf_i_q <= '0;
      end
    end
  end

  assign evicted_valid_o        = ev_v_q;
  assign evicted_index_o        = PAGE_W'(ev_i_q);
  assign second_evicted_valid_o = sev_v_q;
  assign second_evicted_index_o = PAGE_W'(sev_i_q);
  assign prefetched_valid_o     = pf_v_q;
  assign prefetched_index_o     = PAGE_W'(pf_i_q);

endmodule

`default_nettype wire

/* rtl/lru_page_replacement_core.sv */
// Touch, fill and unused actions: the controller goes from decode straight to the done_o pulse.
// A fault scans the stamp RAM once, one page a cycle, before done_o.
// With prepaging a second full scan follows before done_o.
// One item at a time; busy_o stays high until the cycle after the done_o pulse.
// Reset (rst_ni low, asynchronous) clears all valid bits, the use clock and the control registers.
// The result word is held from done_o until the next start is accepted; the receiver cannot stall it.
`default_nettype none

module lru_page_replacement_core #(
  parameter int STAMP_BITS = lrupr_pkg::STAMP_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  input  wire  [lrupr_pkg::ACT_W-1:0]      action_i,
  input  wire  [lrupr_pkg::PAGE_W-1:0]     page_index_i,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [lrupr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [lrupr_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                             done_o,
  output logic                             evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]     evicted_index_o,
  output logic                             second_evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]     second_evicted_index_o,
  output logic                             prefetched_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]     prefetched_index_o
);

  import lrupr_pkg::*;

  `include "lru_page_replacement_core_assert.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_ready_o = !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  lrupr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  lrupr_dp #(
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .action_i               (action_i),
    .page_index_i           (page_index_i),
    .cfg_we_i               (cfg_we),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .evicted_valid_o        (evicted_valid_o),
    .evicted_index_o        (evicted_index_o),
    .second_evicted_valid_o (second_evicted_valid_o),
    .second_evicted_index_o (second_evicted_index_o),
    .prefetched_valid_o     (prefetched_valid_o),
    .prefetched_index_o     (prefetched_index_o)
  );

  `LRUPR_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted word did not raise busy")
  `LRUPR_ASSERT_NEXT(a_done_idle, done_o, !busy_o && !done_o, "no return to idle after result")
  `LRUPR_ASSERT_SAME(a_done_busy, done_o, busy_o, "result strobe outside an item")
  `LRUPR_ASSERT_SAME(a_second_fault, done_o && second_evicted_valid_o, sts.prepaging,
                     "second eviction without prepaging")

endmodule

`default_nettype wire
